### rtl/core/b64d_pkg.sv
`timescale 1ns / 1ps
// types, constants and the character map shared by the base64 stream decoder
// no dependencies

package b64d_pkg;

  localparam int CharW = 8;
  localparam int SextetW = 6;
  localparam int StoreW = 3 * SextetW;
  localparam int TripleW = 4 * SextetW;

  localparam logic [CharW-1:0] PadChar = 8'h3D;
  localparam logic [CharW-1:0] PlusChar = 8'h2B;
  localparam logic [CharW-1:0] SlashChar = 8'h2F;
  localparam logic [CharW-1:0] UpperFirst = 8'h41;
  localparam logic [CharW-1:0] UpperLast = 8'h5A;
  localparam logic [CharW-1:0] LowerFirst = 8'h61;
  localparam logic [CharW-1:0] LowerLast = 8'h7A;
  localparam logic [CharW-1:0] DigitFirst = 8'h30;
  localparam logic [CharW-1:0] DigitLast = 8'h39;

  localparam logic [SextetW-1:0] PlusSextet = 6'h3E;
  localparam logic [SextetW-1:0] SlashSextet = 6'h3F;
  localparam logic [SextetW-1:0] LowerBase = 6'h1A;
  localparam logic [SextetW-1:0] DigitBase = 6'h34;

  localparam logic [1:0] LastPos = 2'd3;
  localparam logic [1:0] ThirdPos = 2'd2;

  // one unit of work for the back end: up to three bytes of a quad,
  // or a single length error
  typedef struct packed {
    logic [TripleW-1:0] triple;
    logic [1:0]         count;
    logic               eom;
    logic               err;
  } job_t;

  function automatic logic [SextetW-1:0] char_to_sextet(input logic [CharW-1:0] c);
    logic [CharW-1:0] d;
    d = '0;
    if (c >= UpperFirst && c <= UpperLast) begin
      d = c - UpperFirst;
    end else if (c >= LowerFirst && c <= LowerLast) begin
      d = (c - LowerFirst) + {2'b00, LowerBase};
    end else if (c >= DigitFirst && c <= DigitLast) begin
      d = (c - DigitFirst) + {2'b00, DigitBase};
    end else if (c == PlusChar) begin
      d = {2'b00, PlusSextet};
    end else if (c == SlashChar) begin
      d = {2'b00, SlashSextet};
    end
    return d[SextetW-1:0];
  endfunction

endpackage

### rtl/core/b64d_if.sv
`timescale 1ns / 1ps
// valid/ready channel interfaces for encoded characters and decoded bytes
// depends on nothing

interface b64d_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_message;

  modport source (output valid, output char_code, output end_of_message, input ready);
  modport sink (input valid, input char_code, input end_of_message, output ready);
endinterface

interface b64d_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       message_done;
  logic       length_error;
  logic       run_last;

  modport source (output valid, output data_byte, output message_done,
                  output length_error, output run_last, input ready);
  modport sink (input valid, input data_byte, input message_done,
                input length_error, input run_last, output ready);
endinterface

### rtl/core/base64_stream_decoder_unit.sv
`timescale 1ns / 1ps
// top level of the base64 stream decoder
// depends on b64d_pkg, b64d_if, b64d_front, b64d_queue, b64d_back
//
// enc carries one base64 character per transfer with an end-of-message flag.
// dec carries decoded bytes, three per complete quad (fewer on a padded final
// quad), or one error result when a message ends inside a quad.
// run_last marks the last result caused by one character; message_done marks
// the final result of a message.
// the first byte of a quad is registered in the job queue, then in the byte
// sender before it can transfer.
// throughput: one character per cycle while the job queue has room; the back
// end sends one byte per cycle while dec is ready, three bytes per full quad.
// the job queue of QUEUE_DEPTH entries sits between the quad builder and the
// byte sender; enc.ready drops only when that queue is full.
// when dec stalls, the current byte holds and the queue absorbs new quads.
// synchronous reset clears the partial quad, the queue and the byte sender.

module base64_stream_decoder_unit
  import b64d_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  b64d_char_if.sink   enc,
  b64d_byte_if.source dec
);

  job_t push_job;
  logic push_valid;
  logic push_ready;
  job_t pop_job;
  logic pop_valid;
  logic pop_ready;

  b64d_front u_front (
    .clk        (clk),
    .rst        (rst),
    .enc        (enc),
    .push_job   (push_job),
    .push_valid (push_valid),
    .push_ready (push_ready)
  );

  b64d_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_job   (push_job),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .pop_job    (pop_job),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready)
  );

  b64d_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_job   (pop_job),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .dec       (dec)
  );

endmodule

### rtl/core/b64d_front.sv
`timescale 1ns / 1ps
// front end: takes characters, maps them to sextets, builds quads and
// pushes byte jobs; depends on b64d_pkg and b64d_char_if

module b64d_front
  import b64d_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  b64d_char_if.sink  enc,
  output job_t       push_job,
  output logic       push_valid,
  input  logic       push_ready
);

  logic [StoreW-1:0]  store;
  logic [1:0]         pos;
  logic               third_pad;
  logic [SextetW-1:0] sx;
  logic               is_pad;
  logic               accept;
  logic               quad_end;
  logic [1:0]         count;

  assign sx = char_to_sextet(enc.char_code);
  assign is_pad = (enc.char_code == PadChar);
  assign enc.ready = push_ready;
  assign accept = enc.valid && enc.ready;
  assign quad_end = (pos == LastPos);

  // padding only trims the final quad
  always_comb begin
    count = 2'd3;
    if (enc.end_of_message && is_pad) count = count - 2'd1;
    if (enc.end_of_message && third_pad) count = count - 2'd1;
  end

  always_comb begin
    push_valid = accept && (quad_end || enc.end_of_message);
    if (quad_end) begin
      push_job.triple = {store, sx};
      push_job.count = count;
      push_job.eom = enc.end_of_message;
      push_job.err = 1'b0;
    end else begin
      push_job.triple = '0;
      push_job.count = 2'd1;
      push_job.eom = 1'b1;
      push_job.err = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      store <= '0;
      pos <= '0;
      third_pad <= 1'b0;
    end else if (accept) begin
      if (quad_end || enc.end_of_message) begin
        store <= '0;
        pos <= '0;
        third_pad <= 1'b0;
      end else begin
        store <= {store[StoreW-SextetW-1:0], sx};
        if (pos == ThirdPos) third_pad <= is_pad;
        pos <= pos + 2'd1;
      end
    end
  end

endmodule

### rtl/core/b64d_queue.sv
`timescale 1ns / 1ps
// small job queue between front and back end
// depends on b64d_pkg

module b64d_queue
  import b64d_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic clk,
  input  logic rst,
  input  job_t push_job,
  input  logic push_valid,
  output logic push_ready,
  output job_t pop_job,
  output logic pop_valid,
  input  logic pop_ready
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] PtrMax = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

  job_t            slots [DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] fill;
  logic            do_push;
  logic            do_pop;

  assign push_ready = (fill != CntFull);
  assign pop_valid = (fill != '0);
  assign pop_job = slots[rd_ptr];
  assign do_push = push_valid && push_ready;
  assign do_pop = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == PtrMax) ? '0 : wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= (rd_ptr == PtrMax) ? '0 : rd_ptr + 1'b1;
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

### rtl/core/b64d_back.sv
`timescale 1ns / 1ps
// back end: holds one job and sends its bytes one transfer at a time
// depends on b64d_pkg and b64d_byte_if

module b64d_back
  import b64d_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  job_t      pop_job,
  input  logic      pop_valid,
  output logic      pop_ready,
  b64d_byte_if.source dec
);

  job_t       cur;
  logic       busy;
  logic [1:0] idx;
  logic       last;
  logic       out_accept;

  assign last = (idx == cur.count - 2'd1);
  assign out_accept = dec.valid && dec.ready;
  // refill when empty or when the final byte of the job leaves
  assign pop_ready = !busy || (out_accept && last);

  always_comb begin
    unique case (idx)
      2'd0: dec.data_byte = cur.triple[23:16];
      2'd1: dec.data_byte = cur.triple[15:8];
      default: dec.data_byte = cur.triple[7:0];
    endcase
  end

  assign dec.valid = busy;
  assign dec.message_done = cur.eom && last;
  assign dec.length_error = cur.err;
  assign dec.run_last = last;

  always_ff @(posedge clk) begin
    if (pop_valid && pop_ready) cur <= pop_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx <= '0;
    end else if (pop_ready) begin
      busy <= pop_valid;
      idx <= '0;
    end else if (out_accept) begin
      idx <= idx + 2'd1;
    end
  end

endmodule

### verif/b64d_decode_check.sv
`timescale 1ns / 1ps
// checker for the base64 stream decoder: decodes the character transfers on its own
// and compares every byte transfer with the oldest byte still owed
// depends on b64d_pkg and b64d_if

module b64d_decode_check
  import b64d_pkg::*;
(
  input  logic clk,
  input  logic rst,
  b64d_char_if enc,
  b64d_byte_if dec,
  output int   failures,
  output int   bytes_outstanding
);

  typedef struct packed {
    logic [7:0] data_byte;
    logic       message_done;
    logic       length_error;
    logic       run_last;
  } decoded_byte_t;

  decoded_byte_t     expected_bytes[$];
  logic [StoreW-1:0] sextet_acc;
  logic [1:0]        quad_pos;
  logic              third_pad;
  int                mismatch_count = 0;

  assign failures = mismatch_count;

  function automatic logic [SextetW-1:0] sextet_of(input logic [7:0] c);
    logic [7:0] v;
    v = 8'h00;
    if (c >= "A" && c <= "Z") begin
      v = c - "A";
    end else if (c >= "a" && c <= "z") begin
      v = c - "a" + {2'b00, LowerBase};
    end else if (c >= "0" && c <= "9") begin
      v = c - "0" + {2'b00, DigitBase};
    end else if (c == "+") begin
      v = {2'b00, PlusSextet};
    end else if (c == "/") begin
      v = {2'b00, SlashSextet};
    end
    // pad and every unknown code decode as a zero sextet
    return v[SextetW-1:0];
  endfunction

  task automatic clear_quad();
    sextet_acc = '0;
    quad_pos = '0;
    third_pad = 1'b0;
  endtask

  task automatic decode_char(input logic [7:0] c, input logic eom);
    logic [SextetW-1:0] sx;
    logic [TripleW-1:0] triple;
    decoded_byte_t      b;
    int                 nbytes;
    int                 k;
    sx = sextet_of(c);
    if (quad_pos != LastPos) begin
      if (eom) begin
        // message ends inside a quad: single error result, partial quad dropped
        b.data_byte = 8'h00;
        b.message_done = 1'b1;
        b.length_error = 1'b1;
        b.run_last = 1'b1;
        expected_bytes.push_back(b);
        clear_quad();
      end else begin
        sextet_acc = {sextet_acc[StoreW-SextetW-1:0], sx};
        if (quad_pos == ThirdPos) begin
          third_pad = (c == PadChar);
        end
        quad_pos = quad_pos + 2'd1;
      end
    end else begin
      triple = {sextet_acc, sx};
      nbytes = 3;
      // padding only trims bytes on the final quad of a message
      if (eom && c == PadChar) begin
        nbytes--;
      end
      if (eom && third_pad) begin
        nbytes--;
      end
      for (k = 0; k < nbytes; k++) begin
        b.data_byte = triple[TripleW-1-8*k -: 8];
        b.message_done = eom && (k == nbytes - 1);
        b.length_error = 1'b0;
        b.run_last = (k == nbytes - 1);
        expected_bytes.push_back(b);
      end
      clear_quad();
    end
  endtask

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("%0t: decoded byte mismatch on %s: got %h, expected %h", $time, what, got,
             want);
    mismatch_count++;
  endtask

  always @(posedge clk) begin : watch
    decoded_byte_t want;
    if (rst) begin
      clear_quad();
      expected_bytes.delete();
      bytes_outstanding <= 0;
    end else begin
      if (enc.valid && enc.ready) begin
        decode_char(enc.char_code, enc.end_of_message);
      end
      if (dec.valid && dec.ready) begin
        if (expected_bytes.size() == 0) begin
          report_mismatch("unexpected transfer", dec.data_byte, 8'h00);
        end else begin
          want = expected_bytes.pop_front();
          if (dec.data_byte !== want.data_byte) begin
            report_mismatch("data_byte", dec.data_byte, want.data_byte);
          end
          if (dec.message_done !== want.message_done) begin
            report_mismatch("message_done", {7'b0, dec.message_done},
                            {7'b0, want.message_done});
          end
          if (dec.length_error !== want.length_error) begin
            report_mismatch("length_error", {7'b0, dec.length_error},
                            {7'b0, want.length_error});
          end
          if (dec.run_last !== want.run_last) begin
            report_mismatch("run_last", {7'b0, dec.run_last}, {7'b0, want.run_last});
          end
        end
      end
      bytes_outstanding <= expected_bytes.size();
    end
  end

endmodule

### verif/tb_base64_stream_decoder_unit.sv
`timescale 1ns / 1ps
// testbench top for the base64 stream decoder: drives characters, pulls bytes
// with random stalls and gives the verdict; depends on b64d_pkg, b64d_if,
// b64d_decode_check and base64_stream_decoder_unit

module tb_base64_stream_decoder_unit;
  import b64d_pkg::*;

  localparam int HoldCycles = 400;
  localparam int ItemTarget = 360;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic send_gaps = 1'b0;
  logic hold_req = 1'b0;
  int   items_sent = 0;
  int   failures;
  int   results_outstanding;

  b64d_char_if enc_ch ();
  b64d_byte_if dec_ch ();

  base64_stream_decoder_unit DUT (
    .clk (clk),
    .rst (rst),
    .enc (enc_ch),
    .dec (dec_ch)
  );

  b64d_decode_check u_decode_check (
    .clk               (clk),
    .rst               (rst),
    .enc               (enc_ch),
    .dec               (dec_ch),
    .failures          (failures),
    .bytes_outstanding (results_outstanding)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [7:0] alphabet_char(input int unsigned n);
    if (n < 26) begin
      return 8'("A" + n);
    end else if (n < 52) begin
      return 8'("a" + (n - 26));
    end else if (n < 62) begin
      return 8'("0" + (n - 52));
    end else if (n == 62) begin
      return "+";
    end
    return "/";
  endfunction

  task automatic send_char(input logic [7:0] c, input logic eom);
    int gap;
    gap = send_gaps ? $urandom_range(0, 19) : 0;
    if (gap != 0) begin
      enc_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    enc_ch.valid <= 1'b1;
    enc_ch.char_code <= c;
    enc_ch.end_of_message <= eom;
    @(posedge clk);
    while (!enc_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_text(input string s, input logic eom);
    int i;
    for (i = 0; i < s.len(); i++) begin
      send_char(s[i], eom && (i == s.len() - 1));
    end
  endtask

  task automatic send_message();
    int         nquads;
    int         npad;
    int         len;
    int         i;
    int         pick;
    logic [7:0] c;
    send_gaps = ($urandom_range(0, 3) != 0);
    if ($urandom_range(0, 4) != 0) begin
      // well-formed: whole quads, final one padded 0..2 times
      nquads = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 10) : $urandom_range(1, 3);
      npad = $urandom_range(0, 2);
      len = 4 * nquads;
      for (i = 0; i < len; i++) begin
        c = (i >= len - npad) ? PadChar : alphabet_char($urandom_range(0, 63));
        send_char(c, i == len - 1);
      end
    end else begin
      // noise: length 1 to 13, stray pads and codes outside the alphabet
      len = $urandom_range(1, 13);
      for (i = 0; i < len; i++) begin
        pick = $urandom_range(0, 3);
        if (pick == 0) begin
          c = PadChar;
        end else if (pick == 1) begin
          c = alphabet_char($urandom_range(0, 63));
        end else begin
          c = 8'($urandom_range(0, 255));
        end
        send_char(c, i == len - 1);
      end
    end
  endtask

  initial begin : stimulus
    int i;
    enc_ch.valid <= 1'b0;
    enc_ch.char_code <= 8'h00;
    enc_ch.end_of_message <= 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    send_gaps = 1'b1;
    send_text("////", 1'b0);
    send_char(8'h00, 1'b0);
    send_char(8'hFF, 1'b0);
    send_text("+9", 1'b0);
    send_text("TWE=", 1'b1);
    // pad in the third slot alone still trims a byte
    send_text("AB=C", 1'b1);
    send_text("=A==", 1'b1);
    send_text("Zz0", 1'b1);
    send_text("A", 1'b1);

    while (items_sent < ItemTarget / 2) send_message();

    // receiver holds off while characters keep coming, so the job queue fills
    hold_req = 1'b1;
    send_gaps = 1'b0;
    for (i = 0; i < 48; i++) begin
      send_char(alphabet_char($urandom_range(0, 63)), i == 47);
    end
    enc_ch.valid <= 1'b0;
    // the owed count seen here must include the last transfer
    @(posedge clk);
    while (results_outstanding != 0) @(posedge clk);

    while (items_sent < ItemTarget) send_message();
    enc_ch.valid <= 1'b0;

    @(posedge clk);
    while (results_outstanding != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (failures == 0) begin
      $display("** base64_stream_decoder_unit: PASSED **");
    end else begin
      $display("** base64_stream_decoder_unit: FAILED **");
    end
    $finish;
  end

  initial begin : receiver
    int   stall;
    int   burst;
    logic stalls_on;
    logic held;
    dec_ch.ready <= 1'b0;
    burst = 0;
    stalls_on = 1'b0;
    held = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (burst == 0) begin
        burst = $urandom_range(10, 40);
        stalls_on = ($urandom_range(0, 3) != 0);
      end
      burst--;
      stall = stalls_on ? $urandom_range(0, 19) : 0;
      if (hold_req && !held) begin
        held = 1'b1;
        stall = HoldCycles;
      end
      if (stall != 0) begin
        dec_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      dec_ch.ready <= 1'b1;
      @(posedge clk);
      while (!dec_ch.valid) @(posedge clk);
    end
  end

  initial begin : watchdog
    #1000000;
    $display("** base64_stream_decoder_unit: FAILED **");
    $finish;
  end

endmodule

### filelist.f
rtl/core/b64d_pkg.sv
rtl/core/b64d_if.sv
rtl/core/b64d_front.sv
rtl/core/b64d_queue.sv
rtl/core/b64d_back.sv
rtl/core/base64_stream_decoder_unit.sv
verif/b64d_decode_check.sv
verif/tb_base64_stream_decoder_unit.sv
